FILE: rtl/tdsv_pkg.sv
// Shared types and constants for the target direction / side / view-cone block.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package tdsv_pkg;

  localparam int POS_W      = 31;  // Q14.16 positions
  localparam int Q14_W      = 16;  // Q1.14 vectors and cosines
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_BITS  = 28;  // quotient bits of the component ratio

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBSERVER_X,
    REG_OBSERVER_Y,
    REG_OBSERVER_Z,
    REG_FACING_X,
    REG_FACING_Y,
    REG_FACING_Z,
    REG_COS_HALF_VIEW
  } cfg_reg_t;

  localparam logic signed [POS_W-1:0] OBSERVER_RST = '0;
  localparam logic signed [Q14_W-1:0] FACING_XY_RST = '0;
  localparam logic signed [Q14_W-1:0] FACING_Z_RST = 16'sd16384;
  localparam logic signed [Q14_W-1:0] COS_RST = 16'sd8192;
  localparam logic signed [Q14_W-1:0] UNIT_Q14 = 16'sd16384;

  localparam logic [1:0] SIDE_ON    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;

  typedef struct packed {
    logic [2:0] sgn;   // sign of d_x, d_y, d_z
    logic       zero;  // zero offset
    logic [1:0] side;
  } tdsv_meta_t;

endpackage

`default_nettype wire

FILE: rtl/target_direction_side_view_test.sv
// Top level: offset to target, unit direction, distance, side and view-cone flag.
// Uses tdsv_pkg, tdsv_div and tdsv_sqrt.
//
// Takes one target per clock and returns one result per target, in order; done
// marks the result for one cycle and the receiver cannot stall it. The latency
// comes from the direction path: a 29-stage bit-per-stage divider forming each
// component's share of the squared length, followed by a 15-stage square root.
// busy is high only during reset. Registers are written through
// cfg_valid/cfg_ready and must only change while no target is in flight.
`default_nettype none

module target_direction_side_view_test
  import tdsv_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [POS_W-1:0]     target_x,
  input  wire logic signed [POS_W-1:0]     target_y,
  input  wire logic signed [POS_W-1:0]     target_z,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data,
  output logic                             done,
  output logic signed [Q14_W-1:0]          dir_x,
  output logic signed [Q14_W-1:0]          dir_y,
  output logic signed [Q14_W-1:0]          dir_z,
  output logic [31:0]                      distance,
  output logic [1:0]                       side,
  output logic                             in_view
);

  localparam int DSQ_W   = FRAC_BITS + 2;           // ratio padded to even width
  localparam int DIV_LAT = FRAC_BITS + 1;
  localparam int DSQ_LAT = DSQ_W / 2;
  localparam int LSQ_LAT = 32;
  localparam int T_IN    = 3;                       // stage feeding the long units
  localparam int T_DIR   = T_IN + DIV_LAT + DSQ_LAT;
  localparam int T_DIST  = T_IN + LSQ_LAT;
  localparam int T_OUT   = T_DIR + 1;
  localparam int META_N  = T_DIR - T_IN;
  localparam int VIEW_N  = T_DIR - 6;
  localparam int DIST_N  = T_DIR - T_DIST;

  // configuration
  logic signed [POS_W-1:0] observer_x, observer_y, observer_z;
  logic signed [Q14_W-1:0] facing_x, facing_y, facing_z, cos_half_view;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      observer_x    <= OBSERVER_RST;
      observer_y    <= OBSERVER_RST;
      observer_z    <= OBSERVER_RST;
      facing_x      <= FACING_XY_RST;
      facing_y      <= FACING_XY_RST;
      facing_z      <= FACING_Z_RST;
      cos_half_view <= COS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OBSERVER_X:    observer_x    <= cfg_data[POS_W-1:0];
        REG_OBSERVER_Y:    observer_y    <= cfg_data[POS_W-1:0];
        REG_OBSERVER_Z:    observer_z    <= cfg_data[POS_W-1:0];
        REG_FACING_X:      facing_x      <= cfg_data[Q14_W-1:0];
        REG_FACING_Y:      facing_y      <= cfg_data[Q14_W-1:0];
        REG_FACING_Z:      facing_z      <= cfg_data[Q14_W-1:0];
        REG_COS_HALF_VIEW: cos_half_view <= cfg_data[Q14_W-1:0];
        default: ;
      endcase
    end
  end

  // valid line
  logic vld_q [0:T_OUT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < T_OUT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start && !busy;
      for (int i = 1; i < T_OUT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // stage 1: offset
  logic signed [31:0] dx1, dy1, dz1;

  always_ff @(posedge clk) begin
    dx1 <= 32'(target_x) - 32'(observer_x);
    dy1 <= 32'(target_y) - 32'(observer_y);
    dz1 <= 32'(target_z) - 32'(observer_z);
  end

  // stage 2: squares and facing products
  logic [31:0]        ax1, ay1, az1;
  logic [63:0]        sx2, sy2, sz2;
  logic signed [47:0] pfx2, pfy2, pfz2, cfz2, cfx2;
  logic [2:0]         sgn2;

  assign ax1 = dx1[31] ? 32'(-dx1) : 32'(dx1);
  assign ay1 = dy1[31] ? 32'(-dy1) : 32'(dy1);
  assign az1 = dz1[31] ? 32'(-dz1) : 32'(dz1);

  always_ff @(posedge clk) begin
    sx2  <= ax1 * ax1;
    sy2  <= ay1 * ay1;
    sz2  <= az1 * az1;
    pfx2 <= facing_x * dx1;
    pfy2 <= facing_y * dy1;
    pfz2 <= facing_z * dz1;
    cfz2 <= facing_z * dx1;
    cfx2 <= facing_x * dz1;
    sgn2 <= {dx1[31], dy1[31], dz1[31]};
  end

  // stage 3: squared length, dot and cross-y
  logic [63:0]        len2_3, sx3, sy3, sz3;
  logic signed [49:0] dot3;
  logic signed [48:0] cross3;
  logic [2:0]         sgn3;

  always_ff @(posedge clk) begin
    len2_3 <= sx2 + sy2 + sz2;
    sx3    <= sx2;
    sy3    <= sy2;
    sz3    <= sz2;
    dot3   <= 50'(pfx2) + 50'(pfy2) + 50'(pfz2);
    cross3 <= 49'(cfz2) - 49'(cfx2);
    sgn3   <= sgn2;
  end

  // direction path: ratio then root
  logic [FRAC_BITS:0]   qx, qy, qz;
  logic [DSQ_W/2-1:0]   rx, ry, rz;
  logic [31:0]          dist_root;

  tdsv_div #(.W(64), .QB(FRAC_BITS)) u_div_x (.clk(clk), .num(sx3), .den(len2_3), .quo(qx));
  tdsv_div #(.W(64), .QB(FRAC_BITS)) u_div_y (.clk(clk), .num(sy3), .den(len2_3), .quo(qy));
  tdsv_div #(.W(64), .QB(FRAC_BITS)) u_div_z (.clk(clk), .num(sz3), .den(len2_3), .quo(qz));

  tdsv_sqrt #(.IN_W(DSQ_W)) u_dsq_x (.clk(clk), .din({1'b0, qx}), .root(rx));
  tdsv_sqrt #(.IN_W(DSQ_W)) u_dsq_y (.clk(clk), .din({1'b0, qy}), .root(ry));
  tdsv_sqrt #(.IN_W(DSQ_W)) u_dsq_z (.clk(clk), .din({1'b0, qz}), .root(rz));

  tdsv_sqrt #(.IN_W(64)) u_lsq (.clk(clk), .din(len2_3), .root(dist_root));

  // stage 4: side, zero, |dot|, cos^2
  tdsv_meta_t         meta3;
  tdsv_meta_t         meta_q [0:META_N-1];
  logic [47:0]        ad4;
  logic               dotneg4, dotneg5, dotneg6;
  logic [63:0]        len2_4;
  logic [15:0]        ac3;
  logic [31:0]        ac2_4;

  always_comb begin
    meta3.sgn  = sgn3;
    meta3.zero = len2_3 == '0;
    if (cross3 > 0)      meta3.side = SIDE_RIGHT;
    else if (cross3 < 0) meta3.side = SIDE_LEFT;
    else                 meta3.side = SIDE_ON;
  end

  assign ac3 = cos_half_view[15] ? 16'(-cos_half_view) : 16'(cos_half_view);

  always_ff @(posedge clk) begin
    meta_q[0] <= meta3;
    for (int i = 1; i < META_N; i++) meta_q[i] <= meta_q[i-1];
    ad4     <= dot3[49] ? 48'(-dot3) : dot3[47:0];
    dotneg4 <= dot3[49];
    len2_4  <= len2_3;
    ac2_4   <= ac3 * ac3;
  end

  // stage 5: partial products of dot^2 and cos^2 * len^2
  logic [47:0] hh5, hl5, ll5;
  logic [63:0] qh5, ql5;

  always_ff @(posedge clk) begin
    hh5     <= ad4[47:24] * ad4[47:24];
    hl5     <= ad4[47:24] * ad4[23:0];
    ll5     <= ad4[23:0] * ad4[23:0];
    qh5     <= ac2_4 * len2_4[63:32];
    ql5     <= ac2_4 * len2_4[31:0];
    dotneg5 <= dotneg4;
  end

  // stage 6: assemble the two squares
  logic [95:0] p6, q6;

  always_ff @(posedge clk) begin
    p6      <= (96'(hh5) << 48) + (96'(hl5) << 25) + 96'(ll5);
    q6      <= (96'(qh5) << 32) + 96'(ql5);
    dotneg6 <= dotneg5;
  end

  // stage 7: cone test, sign-aware compare of squares
  logic view6;
  logic view_q [0:VIEW_N-1];

  assign view6 = !cos_half_view[15] ? (!dotneg6 && (p6 >= q6))
                                    : (!dotneg6 || (p6 <= q6));

  always_ff @(posedge clk) begin
    view_q[0] <= view6;
    for (int i = 1; i < VIEW_N; i++) view_q[i] <= view_q[i-1];
  end

  // distance delay to the direction stage
  logic [31:0] dist_q [0:DIST_N-1];

  always_ff @(posedge clk) begin
    dist_q[0] <= dist_root;
    for (int i = 1; i < DIST_N; i++) dist_q[i] <= dist_q[i-1];
  end

  // output stage
  tdsv_meta_t         meta_o;
  logic signed [15:0] ux, uy, uz;

  assign meta_o = meta_q[META_N-1];
  assign ux = 16'($signed({1'b0, rx}));
  assign uy = 16'($signed({1'b0, ry}));
  assign uz = 16'($signed({1'b0, rz}));

  always_ff @(posedge clk) begin
    if (meta_o.zero) begin
      dir_x    <= '0;
      dir_y    <= '0;
      dir_z    <= '0;
      distance <= '0;
      side     <= SIDE_ON;
      in_view  <= 1'b1;
    end else begin
      dir_x    <= meta_o.sgn[2] ? -ux : ux;
      dir_y    <= meta_o.sgn[1] ? -uy : uy;
      dir_z    <= meta_o.sgn[0] ? -uz : uz;
      distance <= dist_q[DIST_N-1];
      side     <= meta_o.side;
      in_view  <= view_q[VIEW_N-1];
    end
  end

  assign done = vld_q[T_OUT-1];

endmodule

`default_nettype wire

FILE: rtl/tdsv_div.sv
// Pipelined restoring divider: floor(num * 2^QB / den) for num <= den.
// One quotient bit per stage, QB+1 stages. No package dependencies.
`default_nettype none

module tdsv_div #(
  parameter int W  = 64,
  parameter int QB = 28
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic [QB:0]       quo
);

  localparam int QW = QB + 1;

  logic [W-1:0]  rem_q [0:QB];
  logic [W-1:0]  den_q [0:QB];
  logic [QW-1:0] q_q   [0:QB];

  // integer bit: set when num >= den, so only when num equals den for num <= den
  always_ff @(posedge clk) begin
    if (num >= den) begin
      q_q[0]   <= QW'(1);
      rem_q[0] <= num - den;
    end else begin
      q_q[0]   <= '0;
      rem_q[0] <= num;
    end
    den_q[0] <= den;
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [W:0] sh;
    logic [W:0] diff;
    logic       ge;

    assign sh   = {rem_q[s-1], 1'b0};
    assign ge   = sh >= {1'b0, den_q[s-1]};
    assign diff = sh - {1'b0, den_q[s-1]};

    always_ff @(posedge clk) begin
      rem_q[s] <= ge ? diff[W-1:0] : sh[W-1:0];
      den_q[s] <= den_q[s-1];
      q_q[s]   <= {q_q[s-1][QW-2:0], ge};
    end
  end

  assign quo = q_q[QB];

endmodule

`default_nettype wire

FILE: rtl/tdsv_sqrt.sv
// Pipelined integer square root, floor(sqrt(din)), one result bit per stage.
// IN_W must be even. No package dependencies.
`default_nettype none

module tdsv_sqrt #(
  parameter int IN_W = 64
) (
  input  wire logic              clk,
  input  wire logic [IN_W-1:0]   din,
  output logic [IN_W/2-1:0]      root
);

  localparam int N = IN_W / 2;

  logic [IN_W-1:0] v_q [0:N-1];
  logic [IN_W-1:0] r_q [0:N-1];

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam logic [IN_W:0] BIT = (IN_W+1)'(1) << (IN_W - 2 - 2*s);
    logic [IN_W-1:0] v_in;
    logic [IN_W-1:0] r_in;
    logic [IN_W:0]   trial;

    if (s == 0) begin : g_first
      assign v_in = din;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign r_in = r_q[s-1];
    end

    assign trial = {1'b0, r_in} + BIT;

    always_ff @(posedge clk) begin
      if ({1'b0, v_in} >= trial) begin
        v_q[s] <= v_in - trial[IN_W-1:0];
        r_q[s] <= (r_in >> 1) + BIT[IN_W-1:0];
      end else begin
        v_q[s] <= v_in;
        r_q[s] <= r_in >> 1;
      end
    end
  end

  assign root = r_q[N-1][N-1:0];

endmodule

`default_nettype wire

FILE: rtl/tdsv_chk.sv
// Port-level checker for the target direction block, bound to the top level.
// Uses tdsv_pkg for the side codes.
`default_nettype none

module tdsv_chk
  import tdsv_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    done,
  input wire logic signed [Q14_W-1:0] dir_x,
  input wire logic signed [Q14_W-1:0] dir_y,
  input wire logic signed [Q14_W-1:0] dir_z,
  input wire logic [31:0]             distance,
  input wire logic [1:0]              side,
  input wire logic                    in_view
);

  // reset flushes every item in flight
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // zero distance and zero direction go together
  a_zero_match: assert property (@(posedge clk) disable iff (rst)
    done |-> ((distance == '0) == (dir_x == '0 && dir_y == '0 && dir_z == '0)))
    else $error("distance and direction disagree on zero offset");

  // zero offset is on the line and in view
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && distance == '0) |-> (in_view && side == SIDE_ON))
    else $error("zero offset with side or view wrong");

  // unit components stay within one
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (dir_x <= UNIT_Q14 && dir_x >= -UNIT_Q14 &&
              dir_y <= UNIT_Q14 && dir_y >= -UNIT_Q14 &&
              dir_z <= UNIT_Q14 && dir_z >= -UNIT_Q14))
    else $error("direction component beyond unit");

endmodule

bind target_direction_side_view_test tdsv_chk u_tdsv_chk (.*);

`default_nettype wire

FILE: verif/tdsv_checker.sv
// Checker for the target direction / side / view-cone block: watches the input,
// config and result channels, predicts each result and compares it. Uses tdsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdsv_checker
  import tdsv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic signed [POS_W-1:0] target_x,
  input  wire logic signed [POS_W-1:0] target_y,
  input  wire logic signed [POS_W-1:0] target_z,
  input  wire logic                    cfg_valid,
  input  wire logic                    cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    done,
  input  wire logic signed [Q14_W-1:0] dir_x,
  input  wire logic signed [Q14_W-1:0] dir_y,
  input  wire logic signed [Q14_W-1:0] dir_z,
  input  wire logic [31:0]             distance,
  input  wire logic [1:0]              side,
  input  wire logic                    in_view,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic signed [Q14_W-1:0] dx;
    logic signed [Q14_W-1:0] dy;
    logic signed [Q14_W-1:0] dz;
    logic [31:0]             dlen;
    logic [1:0]              sd;
    logic                    view;
  } view_result_t;

  logic signed [POS_W-1:0] obs_x, obs_y, obs_z;
  logic signed [Q14_W-1:0] face_x, face_y, face_z, cos_half;
  view_result_t expected_views[$];

  assign pending = expected_views.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // sign(d) * floor(sqrt(floor(sq * 2^28 / len2)))
  function automatic logic signed [Q14_W-1:0] unit_comp(input logic signed [63:0] d,
                                                       input logic [127:0] sq,
                                                       input logic [127:0] len2);
    logic [127:0] share;
    logic [63:0]  q;
    share = (sq << FRAC_BITS) / len2;
    q = int_sqrt(share[63:0]);
    return d < 0 ? -q[Q14_W-1:0] : q[Q14_W-1:0];
  endfunction

  function automatic view_result_t predict_view(input logic signed [POS_W-1:0] tx,
                                                input logic signed [POS_W-1:0] ty,
                                                input logic signed [POS_W-1:0] tz);
    logic signed [63:0]  ox, oy, oz, cy, dt, cs;
    logic [127:0]        sx, sy, sz, len2, lhs, rhs, ad, ac;
    view_result_t        r;
    ox = 64'(tx) - 64'(obs_x);
    oy = 64'(ty) - 64'(obs_y);
    oz = 64'(tz) - 64'(obs_z);
    sx = 128'(ox * ox);
    sy = 128'(oy * oy);
    sz = 128'(oz * oz);
    len2 = sx + sy + sz;
    cs = 64'(cos_half);
    cy = 64'(face_z) * ox - 64'(face_x) * oz;
    dt = 64'(face_x) * ox + 64'(face_y) * oy + 64'(face_z) * oz;
    if (len2 == 0) begin
      r = '0;
      r.sd = SIDE_ON;
      r.view = 1'b1;
      return r;
    end
    r.dx = unit_comp(ox, sx, len2);
    r.dy = unit_comp(oy, sy, len2);
    r.dz = unit_comp(oz, sz, len2);
    r.dlen = 32'(int_sqrt(len2[63:0]));
    r.sd = cy > 0 ? SIDE_RIGHT : (cy < 0 ? SIDE_LEFT : SIDE_ON);
    ad = 128'(dt < 0 ? -dt : dt);
    ac = 128'(cs < 0 ? -cs : cs);
    lhs = ad * ad;
    rhs = ac * ac * len2;
    if (cs >= 0) r.view = (dt >= 0) && (lhs >= rhs);
    else r.view = (dt >= 0) || (lhs <= rhs);
    return r;
  endfunction

  always @(posedge clk) begin
    view_result_t got, want;
    if (rst) begin
      obs_x <= OBSERVER_RST;
      obs_y <= OBSERVER_RST;
      obs_z <= OBSERVER_RST;
      face_x <= FACING_XY_RST;
      face_y <= FACING_XY_RST;
      face_z <= FACING_Z_RST;
      cos_half <= COS_RST;
      fail_count <= 0;
      expected_views.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_OBSERVER_X:    obs_x <= cfg_data[POS_W-1:0];
          REG_OBSERVER_Y:    obs_y <= cfg_data[POS_W-1:0];
          REG_OBSERVER_Z:    obs_z <= cfg_data[POS_W-1:0];
          REG_FACING_X:      face_x <= cfg_data[Q14_W-1:0];
          REG_FACING_Y:      face_y <= cfg_data[Q14_W-1:0];
          REG_FACING_Z:      face_z <= cfg_data[Q14_W-1:0];
          REG_COS_HALF_VIEW: cos_half <= cfg_data[Q14_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_views.push_back(predict_view(target_x, target_y, target_z));
      if (done) begin
        got = '{dir_x, dir_y, dir_z, distance, side, in_view};
        if (expected_views.size() == 0) begin
          $display("%0t: result with no item outstanding: %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench top: stimulus for the target direction / side / view-cone block.
// Uses tdsv_pkg, target_direction_side_view_test and tdsv_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import tdsv_pkg::*;

  localparam int LATENCY = 48;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0, rst = 1'b1, start = 1'b0, cfg_valid = 1'b0;
  logic signed [POS_W-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, done, in_view;
  logic signed [Q14_W-1:0] dir_x, dir_y, dir_z;
  logic [31:0] distance;
  logic [1:0] side;
  int fail_count, pending;
  int idle_cycles = 0;

  target_direction_side_view_test u_dut (.*);
  tdsv_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Let every in-flight item drain before touching registers.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Drive one item; leaves start high for a following item in the same burst.
  task automatic send_target(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [POS_W-1:0] z);
    @(negedge clk);
    start <= 1'b1;
    target_x <= x;
    target_y <= y;
    target_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] rand_pos(input int mode);
    case (mode)
      0: return POS_W'($urandom);
      1: return POS_W'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? {1'b0, {(POS_W-1){1'b1}}} : {1'b1, {(POS_W-1){1'b0}}};
      default: return POS_W'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic random_phase(input int n_items, input int mode);
    int sent, burst, gap;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_target(rand_pos($urandom_range(0, 9) == 0 ? 2 : mode),
                    rand_pos($urandom_range(0, 9) == 0 ? 2 : mode),
                    rand_pos(mode));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic write_view(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [15:0] fx,
                            input logic [15:0] fy, input logic [15:0] fz,
                            input logic [15:0] ch);
    write_reg(REG_OBSERVER_X, ox);
    write_reg(REG_OBSERVER_Y, oy);
    write_reg(REG_OBSERVER_Z, oz);
    write_reg(REG_FACING_X, {16'($urandom), fx});
    write_reg(REG_FACING_Y, {16'($urandom), fy});
    write_reg(REG_FACING_Z, {16'($urandom), fz});
    write_reg(REG_COS_HALF_VIEW, {16'($urandom), ch});
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, zero offset, extremes, sides, cone edges
    send_target(0, 0, 0);
    send_target(0, 0, 31'sd65536);
    send_target(0, 0, -31'sd65536);
    send_target(31'sd65536, 0, 0);
    send_target(-31'sd65536, 0, 0);
    send_target(0, 31'sd65536, 0);
    send_target(31'sd65536, 0, 31'sd113512); // 30 deg off the facing, inside the cone
    send_target(31'sd65536, 0, 31'sd37837);  // about 60 deg, on the cone edge
    send_target({1'b0, {30{1'b1}}}, {1'b0, {30{1'b1}}}, {1'b0, {30{1'b1}}});
    send_target({1'b1, 30'b0}, {1'b1, 30'b0}, {1'b1, 30'b0});
    send_target({1'b0, {30{1'b1}}}, {1'b1, 30'b0}, 31'sd1);
    drain();
    write_view(32'({1'b1, 30'b0}), 32'({1'b0, {30{1'b1}}}), 32'({1'b1, 30'b0}),
               16'sh8000, 16'sh7fff, -16'sd16384, -16'sd16384);
    send_target({1'b1, 30'b0}, {1'b0, {30{1'b1}}}, {1'b1, 30'b0});
    send_target({1'b0, {30{1'b1}}}, {1'b1, 30'b0}, {1'b0, {30{1'b1}}});
    send_target(0, 0, 0);
    send_target({1'b1, 30'b0}, 0, 0);
    drain();
    write_view(0, 0, 0, 16'sd16384, 0, 0, 16'sd16384);
    send_target(31'sd100, 0, 0);
    send_target(31'sd100, 31'sd1, 0);
    send_target(-31'sd100, 0, 31'sd5);
    send_target(0, 0, -31'sd3);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_view(32'($urandom), 32'($urandom), 32'($urandom),
                 ph % 3 == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384),
                 ph == 4 ? 16'sd16384 : (ph == 5 ? -16'sd16384 : 16'($urandom)));
      if (ph % 2 == 0) begin
        // small observer near the origin
        write_reg(REG_OBSERVER_X, 32'($signed($urandom_range(0, 200)) - 100));
        write_reg(REG_OBSERVER_Y, 32'($signed($urandom_range(0, 200)) - 100));
        write_reg(REG_OBSERVER_Z, 32'($signed($urandom_range(0, 200)) - 100));
      end
      random_phase(108, ph % 4);
      drain();
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
